[design/wrdc_pkg.sv]
// Shared types, constants and helpers for the wheel rate damping controller.
package wrdc_pkg;

    // Datapath width of rates and velocities (fixed by the Q8.16 fields)
    localparam int DATA_WIDTH = 24;

    // Register widths
    localparam int OFFSET_W = 24;
    localparam int ALPHA_W  = 17;
    localparam int MAG_W    = 23;
    localparam int GAIN_W   = 16;

    // APB port
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 5;
    localparam int REG_IDX_W = 3;

    // Register map, by index
    localparam logic [REG_IDX_W-1:0] REG_RATE_OFFSET = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FILTER_ALPHA = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DEADBAND = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DIR_THRESHOLD = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RATE_GAIN = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MIN_SPEED = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MAX_SPEED = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_RAMP_STEP = 3'd7;

    // Reset values
    localparam logic [OFFSET_W-1:0] RST_RATE_OFFSET = 24'd0;
    localparam logic [ALPHA_W-1:0]  RST_FILTER_ALPHA = 17'd13107;
    localparam logic [MAG_W-1:0]    RST_DEADBAND = 23'd1311;
    localparam logic [MAG_W-1:0]    RST_DIR_THRESHOLD = 23'd19661;
    localparam logic [GAIN_W-1:0]   RST_RATE_GAIN = 16'd20480;
    localparam logic [MAG_W-1:0]    RST_MIN_SPEED = 23'd196608;
    localparam logic [MAG_W-1:0]    RST_MAX_SPEED = 23'd5242880;
    localparam logic [MAG_W-1:0]    RST_RAMP_STEP = 23'd3277;

    // Held direction codes (2-bit signed)
    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_POS  = 2'b01;
    localparam logic [1:0] DIR_NEG  = 2'b11;

    // Fractional bits dropped after each product
    localparam int FILT_SHIFT = 16;
    localparam int GAIN_SHIFT = 12;

    // Width of intermediate sums before saturation
    localparam int SAT_W = DATA_WIDTH + 4;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL_F,
        ST_FILT,
        ST_ABS,
        ST_MUL_G,
        ST_TARGET,
        ST_RAMP,
        ST_UPD,
        ST_OUT
    } t_state;

    // Saturate a wide signed sum to the datapath width
    function automatic logic signed [DATA_WIDTH-1:0] sat_data(
        input logic signed [SAT_W-1:0] v
    );
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = {{(SAT_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
        lo = ~hi;
        if (v > hi) begin
            sat_data = hi[DATA_WIDTH-1:0];
        end else if (v < lo) begin
            sat_data = lo[DATA_WIDTH-1:0];
        end else begin
            sat_data = v[DATA_WIDTH-1:0];
        end
    endfunction

endpackage

[design/wrdc_sample_if.sv]
// Input channel: one gyro sample beat per control tick.
interface wrdc_sample_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [wrdc_pkg::DATA_WIDTH-1:0]   gyro_rate;
    logic                                     restart;

    modport source (output valid, output gyro_rate, output restart, input ready);
    modport sink   (input valid, input gyro_rate, input restart, output ready);
endinterface

[design/wrdc_result_if.sv]
// Output channel: one result beat per control tick.
interface wrdc_result_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [wrdc_pkg::DATA_WIDTH-1:0]   wheel_velocity;
    logic signed [wrdc_pkg::DATA_WIDTH-1:0]   target_velocity;
    logic signed [wrdc_pkg::DATA_WIDTH-1:0]   filtered_rate;
    logic signed [1:0]                        direction;

    modport source (output valid, output wheel_velocity, output target_velocity,
                    output filtered_rate, output direction, input ready);
    modport sink   (input valid, input wheel_velocity, input target_velocity,
                    input filtered_rate, input direction, output ready);
endinterface

[design/wheel_rate_damping_controller.sv]
// Wheel rate damping controller: offset, rate filter, target shaping and slew ramp.
// One gyro sample beat gives one result beat. Each accepted sample runs through the states
// DIFF, MUL_F, FILT, ABS, MUL_G, TARGET, RAMP, UPD and OUT; the result is registered on the
// output in OUT, then the sequencer returns to IDLE, the only state that takes a sample. The
// single shared bit-serial multiplier forms the filter product in MUL_F and the gain product
// in MUL_G; the other states are add, compare and ramp steps. A finished result sits in
// the output register while the next sample is already taken; the block stalls only if a
// result is still unclaimed when the following one is ready. Configuration registers sit
// on the APB port at byte address 4*index and are to be written only while the block is
// idle; the block itself does not enforce this. No clearing pass is needed after reset.
module wheel_rate_damping_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    wrdc_sample_if.sink                       i_sample,
    wrdc_result_if.source                     o_result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wrdc_pkg::APB_AW-1:0]       paddr,
    input  logic [wrdc_pkg::APB_DW-1:0]       pwdata,
    output logic [wrdc_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    localparam int DW       = wrdc_pkg::DATA_WIDTH;
    localparam int MCAND_W  = DW + 1;
    localparam int MPL_W    = wrdc_pkg::ALPHA_W;
    localparam int ACC_W    = MCAND_W + MPL_W;
    localparam int DELTA_W  = ACC_W - wrdc_pkg::FILT_SHIFT;
    localparam int MAGP_W   = ACC_W - 1 - wrdc_pkg::GAIN_SHIFT;
    localparam int CNT_W    = $clog2(MPL_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MPL_W - 1);
    localparam int SW       = wrdc_pkg::SAT_W;
    localparam int MW       = wrdc_pkg::MAG_W;

    // Configuration registers
    logic signed [wrdc_pkg::OFFSET_W-1:0] r_rate_offset;
    logic [wrdc_pkg::ALPHA_W-1:0]         r_filter_alpha;
    logic [MW-1:0]                        r_deadband;
    logic [MW-1:0]                        r_dir_threshold;
    logic [wrdc_pkg::GAIN_W-1:0]          r_rate_gain;
    logic [MW-1:0]                        r_min_speed;
    logic [MW-1:0]                        r_max_speed;
    logic [MW-1:0]                        r_ramp_step;

    // Controller state
    logic signed [DW-1:0] r_rate_filter;
    logic [1:0]           r_held_dir;
    logic signed [DW-1:0] r_wheel_speed;

    // Working registers
    wrdc_pkg::t_state      r_state;
    wrdc_pkg::t_state      n_state;
    logic signed [DW-1:0]  r_gz;
    logic signed [MCAND_W-1:0] r_mcand;
    logic [MPL_W-1:0]      r_mplier;
    logic signed [ACC_W-1:0] r_acc;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_pass;
    logic signed [DW-1:0]  r_target;
    logic signed [MCAND_W-1:0] r_diff;

    // Output register
    logic                  r_out_valid;
    logic signed [DW-1:0]  r_out_wheel;
    logic signed [DW-1:0]  r_out_target;
    logic signed [DW-1:0]  r_out_filter;
    logic [1:0]            r_out_dir;

    // Combinational helpers
    logic                  cfg_wr;
    logic [wrdc_pkg::REG_IDX_W-1:0] cfg_idx;
    logic                  in_beat;
    logic                  out_free;
    logic signed [ACC_W-1:0] mul_sel;
    logic [MPL_W-1:0]      alpha_eff;
    logic signed [DELTA_W-1:0] delta;
    logic [DW-1:0]         abs_rate;
    logic                  abs_pass;
    logic [MAGP_W-1:0]     mag;
    logic [MAGP_W-1:0]     mag_lo;
    logic [MAGP_W-1:0]     mag_hi;
    logic signed [DW-1:0]  target_c;
    logic signed [MCAND_W-1:0] diff_raw;
    logic signed [MCAND_W-1:0] step_pos;
    logic signed [MCAND_W-1:0] diff_c;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign cfg_idx  = paddr[wrdc_pkg::APB_AW-1:2];
    assign in_beat  = i_sample.valid & i_sample.ready;
    assign out_free = ~r_out_valid | o_result.ready;

    assign i_sample.ready           = (r_state == wrdc_pkg::ST_IDLE);
    assign o_result.valid           = r_out_valid;
    assign o_result.wheel_velocity  = r_out_wheel;
    assign o_result.target_velocity = r_out_target;
    assign o_result.filtered_rate   = r_out_filter;
    assign o_result.direction       = r_out_dir;

    // Register file writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_offset   <= wrdc_pkg::RST_RATE_OFFSET;
            r_filter_alpha  <= wrdc_pkg::RST_FILTER_ALPHA;
            r_deadband      <= wrdc_pkg::RST_DEADBAND;
            r_dir_threshold <= wrdc_pkg::RST_DIR_THRESHOLD;
            r_rate_gain     <= wrdc_pkg::RST_RATE_GAIN;
            r_min_speed     <= wrdc_pkg::RST_MIN_SPEED;
            r_max_speed     <= wrdc_pkg::RST_MAX_SPEED;
            r_ramp_step     <= wrdc_pkg::RST_RAMP_STEP;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                wrdc_pkg::REG_RATE_OFFSET:   r_rate_offset <= pwdata[wrdc_pkg::OFFSET_W-1:0];
                wrdc_pkg::REG_FILTER_ALPHA:  r_filter_alpha <= pwdata[wrdc_pkg::ALPHA_W-1:0];
                wrdc_pkg::REG_DEADBAND:      r_deadband <= pwdata[MW-1:0];
                wrdc_pkg::REG_DIR_THRESHOLD: r_dir_threshold <= pwdata[MW-1:0];
                wrdc_pkg::REG_RATE_GAIN:     r_rate_gain <= pwdata[wrdc_pkg::GAIN_W-1:0];
                wrdc_pkg::REG_MIN_SPEED:     r_min_speed <= pwdata[MW-1:0];
                wrdc_pkg::REG_MAX_SPEED:     r_max_speed <= pwdata[MW-1:0];
                wrdc_pkg::REG_RAMP_STEP:     r_ramp_step <= pwdata[MW-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        unique case (cfg_idx)
            wrdc_pkg::REG_RATE_OFFSET:
                prdata = {{(wrdc_pkg::APB_DW-wrdc_pkg::OFFSET_W){r_rate_offset[wrdc_pkg::OFFSET_W-1]}},
                          r_rate_offset};
            wrdc_pkg::REG_FILTER_ALPHA:
                prdata = {{(wrdc_pkg::APB_DW-wrdc_pkg::ALPHA_W){1'b0}}, r_filter_alpha};
            wrdc_pkg::REG_DEADBAND:      prdata = {{(wrdc_pkg::APB_DW-MW){1'b0}}, r_deadband};
            wrdc_pkg::REG_DIR_THRESHOLD: prdata = {{(wrdc_pkg::APB_DW-MW){1'b0}}, r_dir_threshold};
            wrdc_pkg::REG_RATE_GAIN:
                prdata = {{(wrdc_pkg::APB_DW-wrdc_pkg::GAIN_W){1'b0}}, r_rate_gain};
            wrdc_pkg::REG_MIN_SPEED:     prdata = {{(wrdc_pkg::APB_DW-MW){1'b0}}, r_min_speed};
            wrdc_pkg::REG_MAX_SPEED:     prdata = {{(wrdc_pkg::APB_DW-MW){1'b0}}, r_max_speed};
            wrdc_pkg::REG_RAMP_STEP:     prdata = {{(wrdc_pkg::APB_DW-MW){1'b0}}, r_ramp_step};
            default:                     prdata = '0;
        endcase
    end

    // Alpha above one acts as exactly one
    assign alpha_eff = r_filter_alpha[MPL_W-1] ? {1'b1, {(MPL_W-1){1'b0}}} : r_filter_alpha;

    // Serial multiplier: one multiplier bit per cycle, MSB first
    assign mul_sel = r_mplier[MPL_W-1]
                   ? {{(ACC_W-MCAND_W){r_mcand[MCAND_W-1]}}, r_mcand}
                   : '0;

    // Filter increment, floored by the arithmetic shift
    assign delta = r_acc[ACC_W-1:wrdc_pkg::FILT_SHIFT];

    // Rate magnitude and deadband test
    assign abs_rate = r_rate_filter[DW-1] ? (~r_rate_filter + 1'b1) : r_rate_filter;
    assign abs_pass = (abs_rate >= {{(DW-MW){1'b0}}, r_deadband});

    // Gain product, raised to the minimum then limited to the maximum
    assign mag    = r_acc[ACC_W-2:wrdc_pkg::GAIN_SHIFT];
    assign mag_lo = (mag < {{(MAGP_W-MW){1'b0}}, r_min_speed})
                  ? {{(MAGP_W-MW){1'b0}}, r_min_speed} : mag;
    assign mag_hi = (mag_lo > {{(MAGP_W-MW){1'b0}}, r_max_speed})
                  ? {{(MAGP_W-MW){1'b0}}, r_max_speed} : mag_lo;

    always_comb begin
        target_c = '0;
        if (r_pass && (r_held_dir != wrdc_pkg::DIR_NONE)) begin
            if (r_held_dir == wrdc_pkg::DIR_NEG) begin
                target_c = -$signed(mag_hi[DW-1:0]);
            end else begin
                target_c = $signed(mag_hi[DW-1:0]);
            end
        end
    end

    // Slew limit
    assign diff_raw = {r_target[DW-1], r_target} - {r_wheel_speed[DW-1], r_wheel_speed};
    assign step_pos = {{(MCAND_W-MW){1'b0}}, r_ramp_step};

    always_comb begin
        if (diff_raw > step_pos) begin
            diff_c = step_pos;
        end else if (diff_raw < -step_pos) begin
            diff_c = -step_pos;
        end else begin
            diff_c = diff_raw;
        end
    end

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wrdc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wrdc_pkg::ST_IDLE:   if (in_beat) n_state = wrdc_pkg::ST_DIFF;
            wrdc_pkg::ST_DIFF:   n_state = wrdc_pkg::ST_MUL_F;
            wrdc_pkg::ST_MUL_F:  if (r_cnt == CNT_LAST) n_state = wrdc_pkg::ST_FILT;
            wrdc_pkg::ST_FILT:   n_state = wrdc_pkg::ST_ABS;
            wrdc_pkg::ST_ABS:    n_state = wrdc_pkg::ST_MUL_G;
            wrdc_pkg::ST_MUL_G:  if (r_cnt == CNT_LAST) n_state = wrdc_pkg::ST_TARGET;
            wrdc_pkg::ST_TARGET: n_state = wrdc_pkg::ST_RAMP;
            wrdc_pkg::ST_RAMP:   n_state = wrdc_pkg::ST_UPD;
            wrdc_pkg::ST_UPD:    n_state = wrdc_pkg::ST_OUT;
            wrdc_pkg::ST_OUT:    if (out_free) n_state = wrdc_pkg::ST_IDLE;
            default:             n_state = wrdc_pkg::ST_IDLE;
        endcase
    end

    // Controller state: cleared by reset and by the restart bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_filter <= '0;
            r_held_dir    <= wrdc_pkg::DIR_NONE;
            r_wheel_speed <= '0;
        end else begin
            case (r_state)
                wrdc_pkg::ST_IDLE: begin
                    if (in_beat && i_sample.restart) begin
                        r_rate_filter <= '0;
                        r_held_dir    <= wrdc_pkg::DIR_NONE;
                        r_wheel_speed <= '0;
                    end
                end
                wrdc_pkg::ST_FILT: begin
                    r_rate_filter <= wrdc_pkg::sat_data(
                        SW'(r_rate_filter) + SW'(delta));
                end
                wrdc_pkg::ST_ABS: begin
                    // zero rate past a zero deadband counts as negative
                    if (abs_pass && (abs_rate > {{(DW-MW){1'b0}}, r_dir_threshold})) begin
                        r_held_dir <= (!r_rate_filter[DW-1] && (r_rate_filter != '0))
                                    ? wrdc_pkg::DIR_POS : wrdc_pkg::DIR_NEG;
                    end
                end
                wrdc_pkg::ST_UPD: begin
                    r_wheel_speed <= wrdc_pkg::sat_data(
                        SW'(r_wheel_speed) + SW'(r_diff));
                end
                default: ;
            endcase
        end
    end

    // Datapath working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            wrdc_pkg::ST_IDLE: begin
                r_gz <= wrdc_pkg::sat_data(SW'(i_sample.gyro_rate) - SW'(r_rate_offset));
            end
            wrdc_pkg::ST_DIFF: begin
                r_mcand  <= {r_gz[DW-1], r_gz} - {r_rate_filter[DW-1], r_rate_filter};
                r_mplier <= alpha_eff;
                r_acc    <= '0;
                r_cnt    <= '0;
            end
            wrdc_pkg::ST_ABS: begin
                r_pass   <= abs_pass;
                r_mcand  <= {1'b0, abs_rate};
                r_mplier <= {{(MPL_W-wrdc_pkg::GAIN_W){1'b0}}, r_rate_gain};
                r_acc    <= '0;
                r_cnt    <= '0;
            end
            wrdc_pkg::ST_MUL_F, wrdc_pkg::ST_MUL_G: begin
                r_acc    <= (r_acc <<< 1) + mul_sel;
                r_mplier <= r_mplier << 1;
                r_cnt    <= r_cnt + 1'b1;
            end
            wrdc_pkg::ST_TARGET: begin
                r_target <= target_c;
            end
            wrdc_pkg::ST_RAMP: begin
                r_diff <= diff_c;
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == wrdc_pkg::ST_OUT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == wrdc_pkg::ST_OUT) && out_free) begin
            r_out_wheel  <= r_wheel_speed;
            r_out_target <= r_target;
            r_out_filter <= r_rate_filter;
            r_out_dir    <= r_held_dir;
        end
    end

endmodule

[test/tb.sv]
// Self-checking testbench for the wheel rate damping controller: tick driver, result monitor.
module tb;

    localparam int DATA_WIDTH = wrdc_pkg::DATA_WIDTH;
    localparam int OFFSET_W   = wrdc_pkg::OFFSET_W;
    localparam int ALPHA_W    = wrdc_pkg::ALPHA_W;
    localparam int MAG_W      = wrdc_pkg::MAG_W;
    localparam int GAIN_W     = wrdc_pkg::GAIN_W;
    localparam int APB_AW     = wrdc_pkg::APB_AW;
    localparam int APB_DW     = wrdc_pkg::APB_DW;
    localparam int REG_IDX_W  = wrdc_pkg::REG_IDX_W;

    localparam int QUIET_LIMIT = 4000;   // cycles with no beat before giving up
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off in the pressure phase
    localparam int RAND_PHASES = 10;
    localparam int PHASE_TICKS = 183;

    // One control tick in, one controller result out
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] gyro_rate;
        logic                         restart;
    } t_tick;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] wheel_velocity;
        logic signed [DATA_WIDTH-1:0] target_velocity;
        logic signed [DATA_WIDTH-1:0] filtered_rate;
        logic signed [1:0]            direction;
    } t_ctrl_out;

    typedef struct {
        logic signed [OFFSET_W-1:0] rate_offset;
        logic [ALPHA_W-1:0]         filter_alpha;
        logic [MAG_W-1:0]           deadband;
        logic [MAG_W-1:0]           dir_threshold;
        logic [GAIN_W-1:0]          rate_gain;
        logic [MAG_W-1:0]           min_speed;
        logic [MAG_W-1:0]           max_speed;
        logic [MAG_W-1:0]           ramp_step;
    } t_damp_cfg;

    // Handshake pacing of both channels
    typedef enum logic [2:0] {
        PACE_FREE,
        PACE_SRC_IDLE,
        PACE_SNK_STALL,
        PACE_BOTH,
        PACE_HOLD_OFF
    } t_pace;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [APB_AW-1:0]            paddr = '0;
    logic [APB_DW-1:0]            pwdata = '0;
    logic [APB_DW-1:0]            prdata;
    logic                         pready;

    logic                         tx_valid = 1'b0;
    logic signed [DATA_WIDTH-1:0] tx_rate = '0;
    logic                         tx_restart = 1'b0;
    logic                         rx_ready = 1'b0;

    wrdc_sample_if sample_bus ();
    wrdc_result_if result_bus ();

    assign sample_bus.valid     = tx_valid;
    assign sample_bus.gyro_rate = tx_rate;
    assign sample_bus.restart   = tx_restart;
    assign result_bus.ready     = rx_ready;

    wheel_rate_damping_controller u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_bus),
        .o_result (result_bus),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Scoreboard state
    t_tick     pending_ticks[$];
    t_ctrl_out expected_outs[$];
    t_tick     cur_tick;
    t_pace     pace = PACE_FREE;
    int        ticks_queued = 0;
    int        results_seen = 0;
    int        mismatches = 0;
    int        hold_cnt = 0;
    int        quiet_cycles = 0;

    // Controller model: configuration copy and state
    t_damp_cfg   ctl_cfg;
    longint      filt_state;
    logic [1:0]  held_dir;
    longint      wheel_cmd;

    function automatic longint clamp_q816(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // One control tick: offset, filter, target shaping, slew
    function automatic t_ctrl_out damp_tick(t_tick t);
        longint    gz;
        longint    alpha;
        longint    absr;
        longint    mag;
        longint    tgt;
        longint    diff;
        longint    stp;
        logic [1:0] now_dir;
        t_ctrl_out r;
        if (t.restart) begin
            filt_state = 0;
            held_dir   = wrdc_pkg::DIR_NONE;
            wheel_cmd  = 0;
        end
        gz = clamp_q816(longint'($signed(t.gyro_rate)) - longint'($signed(ctl_cfg.rate_offset)));
        // weights above one behave as exactly one
        alpha = (ctl_cfg.filter_alpha > 17'd65536) ? 65536 : longint'(ctl_cfg.filter_alpha);
        filt_state = clamp_q816(filt_state +
                                ((alpha * (gz - filt_state)) >>> wrdc_pkg::FILT_SHIFT));
        absr = (filt_state < 0) ? -filt_state : filt_state;
        tgt = 0;
        if (absr >= longint'(ctl_cfg.deadband)) begin
            // a zero rate counts as negative
            now_dir = (filt_state > 0) ? wrdc_pkg::DIR_POS : wrdc_pkg::DIR_NEG;
            if (absr > longint'(ctl_cfg.dir_threshold)) held_dir = now_dir;
            if (held_dir != wrdc_pkg::DIR_NONE) begin
                mag = (longint'(ctl_cfg.rate_gain) * absr) >>> wrdc_pkg::GAIN_SHIFT;
                if (mag < longint'(ctl_cfg.min_speed)) mag = longint'(ctl_cfg.min_speed);
                if (mag > longint'(ctl_cfg.max_speed)) mag = longint'(ctl_cfg.max_speed);
                tgt = (held_dir == wrdc_pkg::DIR_POS) ? mag : -mag;
            end
        end
        stp  = longint'(ctl_cfg.ramp_step);
        diff = tgt - wheel_cmd;
        if (diff > stp) diff = stp;
        if (diff < -stp) diff = -stp;
        wheel_cmd = clamp_q816(wheel_cmd + diff);
        r.wheel_velocity  = DATA_WIDTH'(wheel_cmd);
        r.target_velocity = DATA_WIDTH'(tgt);
        r.filtered_rate   = DATA_WIDTH'(filt_state);
        r.direction       = held_dir;
        return r;
    endfunction

    function automatic t_damp_cfg make_cfg(longint off, longint alpha, longint db,
                                           longint thr, longint gain, longint mn,
                                           longint mx, longint stp);
        t_damp_cfg c;
        c.rate_offset   = OFFSET_W'(off);
        c.filter_alpha  = ALPHA_W'(alpha);
        c.deadband      = MAG_W'(db);
        c.dir_threshold = MAG_W'(thr);
        c.rate_gain     = GAIN_W'(gain);
        c.min_speed     = MAG_W'(mn);
        c.max_speed     = MAG_W'(mx);
        c.ramp_step     = MAG_W'(stp);
        return c;
    endfunction

    // Reset values of the register file
    function automatic t_damp_cfg reset_cfg();
        return make_cfg(longint'($signed(wrdc_pkg::RST_RATE_OFFSET)),
                        wrdc_pkg::RST_FILTER_ALPHA, wrdc_pkg::RST_DEADBAND,
                        wrdc_pkg::RST_DIR_THRESHOLD, wrdc_pkg::RST_RATE_GAIN,
                        wrdc_pkg::RST_MIN_SPEED, wrdc_pkg::RST_MAX_SPEED,
                        wrdc_pkg::RST_RAMP_STEP);
    endfunction

    // Mostly a typical value, sometimes either end of the range
    function automatic longint pick_setting(int unsigned lo, int unsigned hi,
                                            int unsigned typ_lo, int unsigned typ_hi);
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return $urandom_range(typ_hi, typ_lo);
    endfunction

    function automatic t_damp_cfg random_cfg();
        return make_cfg(pick_setting(0, 16777215, 8368608, 8408608) - 8388608,
                        pick_setting(0, 131071, 2000, 70000),
                        pick_setting(0, 8388607, 0, 6000),
                        pick_setting(0, 8388607, 0, 80000),
                        pick_setting(0, 65535, 1000, 65535),
                        pick_setting(0, 8388607, 0, 400000),
                        pick_setting(0, 8388607, 50000, 6000000),
                        pick_setting(0, 8388607, 50, 300000));
    endfunction

    function automatic longint spread(int unsigned m);
        return longint'($urandom_range(2 * m, 0)) - longint'(m);
    endfunction

    task automatic check_field(string name, logic signed [DATA_WIDTH-1:0] want,
                               logic signed [DATA_WIDTH-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_cfg(t_damp_cfg c);
        apb_write(wrdc_pkg::REG_RATE_OFFSET,
                  {{(APB_DW-OFFSET_W){c.rate_offset[OFFSET_W-1]}}, c.rate_offset});
        apb_write(wrdc_pkg::REG_FILTER_ALPHA, APB_DW'(c.filter_alpha));
        apb_write(wrdc_pkg::REG_DEADBAND, APB_DW'(c.deadband));
        apb_write(wrdc_pkg::REG_DIR_THRESHOLD, APB_DW'(c.dir_threshold));
        apb_write(wrdc_pkg::REG_RATE_GAIN, APB_DW'(c.rate_gain));
        apb_write(wrdc_pkg::REG_MIN_SPEED, APB_DW'(c.min_speed));
        apb_write(wrdc_pkg::REG_MAX_SPEED, APB_DW'(c.max_speed));
        apb_write(wrdc_pkg::REG_RAMP_STEP, APB_DW'(c.ramp_step));
        ctl_cfg = c;
    endtask

    task automatic queue_tick(longint rate, bit rst);
        t_tick t;
        t.gyro_rate = DATA_WIDTH'(clamp_q816(rate));
        t.restart   = rst;
        pending_ticks.push_back(t);
        ticks_queued++;
    endtask

    // Wait until every queued tick has produced its result, then a short margin
    task automatic settle();
        while (results_seen != ticks_queued) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Runs of a steady body rate with jitter, some noise and occasional restarts
    task automatic queue_random(int n);
        int unsigned run_left;
        int unsigned jitter;
        int unsigned r;
        longint      level;
        run_left = 0;
        level = 0;
        jitter = 0;
        for (int i = 0; i < n; i++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(60, 5);
                r = $urandom_range(99);
                if (r < 10) level = 0;
                else if (r < 45) level = spread(60000);
                else if (r < 80) level = spread(1500000);
                else level = spread(8388607);
                case ($urandom_range(3))
                    0: jitter = 0;
                    1: jitter = 200;
                    2: jitter = 3000;
                    default: jitter = 50000;
                endcase
            end
            run_left--;
            if ($urandom_range(99) < 12) begin
                queue_tick(spread(8388608), $urandom_range(99) < 2);
            end else begin
                queue_tick(level + longint'($signed(ctl_cfg.rate_offset)) + spread(jitter),
                           $urandom_range(99) < 2);
            end
        end
    endtask

    // Driver: presents pending ticks, predicts each accepted beat
    always @(posedge i_clk) begin : drive_ticks
        logic    slot_free;
        int      idle_pct;
        slot_free = !tx_valid || sample_bus.ready;
        case (pace)
            PACE_SRC_IDLE: idle_pct = 83;
            PACE_BOTH:     idle_pct = 21;
            default:       idle_pct = 0;
        endcase
        if (!i_rst_n) begin
            tx_valid <= 1'b0;
        end else begin
            if (tx_valid && sample_bus.ready) begin
                expected_outs.push_back(damp_tick(cur_tick));
            end
            if (slot_free) begin
                if (pending_ticks.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    cur_tick = pending_ticks.pop_front();
                    tx_valid   <= 1'b1;
                    tx_rate    <= cur_tick.gyro_rate;
                    tx_restart <= cur_tick.restart;
                end else begin
                    tx_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks result beats, paces ready
    always @(posedge i_clk) begin : watch_results
        t_ctrl_out want;
        int        stall_pct;
        case (pace)
            PACE_SNK_STALL: stall_pct = 83;
            PACE_BOTH:      stall_pct = 21;
            default:        stall_pct = 0;
        endcase
        if (!i_rst_n) begin
            rx_ready <= 1'b0;
            hold_cnt <= 0;
        end else begin
            if (result_bus.valid && rx_ready) begin
                if (expected_outs.size() == 0) begin
                    $display("%0t: result beat with nothing expected, got wheel %0d target %0d",
                             $time, result_bus.wheel_velocity, result_bus.target_velocity);
                    mismatches++;
                end else begin
                    want = expected_outs.pop_front();
                    check_field("wheel_velocity", want.wheel_velocity,
                                result_bus.wheel_velocity);
                    check_field("target_velocity", want.target_velocity,
                                result_bus.target_velocity);
                    check_field("filtered_rate", want.filtered_rate, result_bus.filtered_rate);
                    check_field("direction", want.direction, result_bus.direction);
                    results_seen++;
                end
            end
            // long hold-off so the block fills up and stalls its input
            if (pace == PACE_HOLD_OFF && hold_cnt < HOLD_CYCLES) begin
                hold_cnt <= hold_cnt + 1;
                rx_ready <= 1'b0;
            end else begin
                if (pace != PACE_HOLD_OFF) hold_cnt <= 0;
                rx_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Watchdog on beats in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (tx_valid && sample_bus.ready) || (result_bus.valid && rx_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        t_pace phase_pace[RAND_PHASES];
        phase_pace = '{PACE_FREE, PACE_SRC_IDLE, PACE_SNK_STALL, PACE_BOTH, PACE_HOLD_OFF,
                       PACE_FREE, PACE_SRC_IDLE, PACE_SNK_STALL, PACE_BOTH, PACE_FREE};
        ctl_cfg = reset_cfg();
        filt_state = 0;
        held_dir   = wrdc_pkg::DIR_NONE;
        wheel_cmd  = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: full-scale rates both ways, restart into the deadband
        queue_tick(0, 1);
        queue_tick(8388607, 0);
        queue_tick(8388607, 0);
        queue_tick(-8388608, 0);
        queue_tick(-8388608, 0);
        queue_tick(-8388608, 0);
        queue_tick(500, 1);
        queue_tick(20000, 0);
        settle();

        // Weight above one, zero deadband, minimum above maximum, zero rate with held sign
        load_cfg(make_cfg(8388607, 131071, 0, 8388607, 65535, 8388607, 1000, 8388607));
        queue_tick(8388607, 1);
        queue_tick(-1, 0);
        queue_tick(8388607, 0);
        queue_tick(0, 0);
        settle();

        // Saturated offset removal, widest deadband, zero gain and no slew
        load_cfg(make_cfg(-8388608, 65536, 8388607, 0, 0, 0, 8388607, 0));
        queue_tick(8388607, 1);
        queue_tick(-8388608, 0);
        queue_tick(-1, 0);
        settle();

        // Filter frozen by a zero weight
        load_cfg(make_cfg(0, 0, 0, 0, 65535, 0, 8388607, 8388607));
        queue_tick(8388607, 1);
        queue_tick(-8388608, 0);
        settle();

        // Random phases, first one on reset settings
        for (int p = 0; p < RAND_PHASES; p++) begin
            settle();
            if (p == 0) begin
                load_cfg(reset_cfg());
            end else begin
                load_cfg(random_cfg());
            end
            pace = phase_pace[p];
            queue_random(PHASE_TICKS);
        end

        settle();
        pace = PACE_FREE;
        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && expected_outs.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
